// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers, empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// expr holds at every clock edge outside reset
`define SGFS_ASSERT(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("%m: check failed");
// ante implies cons in the same cycle
`define SGFS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: check failed");
// ante implies cons in the next cycle
`define SGFS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: check failed");
`else
`define SGFS_ASSERT(lbl, clk, rst_n, expr)
`define SGFS_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define SGFS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/sgfs_pkg.sv =====
// ----------------------------------------------------------------------------
// sgfs_pkg
// Widths, register codes, run phases and shared types of the gap finder.
// ----------------------------------------------------------------------------
package sgfs_pkg;

    localparam int MAX_SAMPLES = 2048;
    localparam int RANGE_BITS  = 16;

    localparam int IDX_W     = $clog2(MAX_SAMPLES);
    localparam int LEN_W     = IDX_W + 1;
    localparam int RANGE_W   = 16;
    localparam int REF_W     = 13;
    localparam int MINGAP_W  = 12;
    localparam int SCANLEN_W = 12;
    localparam int FHW_W     = 11;
    localparam int RUNLEN_W  = 12;
    localparam int DIST_W    = 13;
    localparam int START_W   = 12;
    localparam int END_W     = 12;
    localparam int PEAK_W    = 11;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [RANGE_W-1:0] RANGE_MASK = RANGE_W'((64'd1 << RANGE_BITS) - 64'd1);

    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_GAP   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SCAN_LEN  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FWD_HALF  = 2'd3;

    localparam logic [RANGE_W-1:0]   RST_THRESHOLD = 16'd1500;
    localparam logic [MINGAP_W-1:0]  RST_MIN_GAP   = 12'd10;
    localparam logic [SCANLEN_W-1:0] RST_SCAN_LEN  = 12'd1080;
    localparam logic [FHW_W-1:0]     RST_FWD_HALF  = 11'd240;

    localparam logic [1:0] PH_IDLE  = 2'd0;
    localparam logic [1:0] PH_CHECK = 2'd1;
    localparam logic [1:0] PH_GAP   = 2'd2;

    typedef struct packed {
        logic [RANGE_W-1:0]     threshold;
        logic [MINGAP_W-1:0]    min_gap;
        logic [LEN_W-1:0]       len;
        logic [IDX_W-1:0]       last_idx;
        logic [IDX_W-1:0]       ws;
        logic [LEN_W-1:0]       we;
        logic signed [LEN_W:0]  start_lim;
    } t_scan_cfg;

    typedef struct packed {
        logic                     en;
        logic [IDX_W-1:0]         beg;
        logic [LEN_W-1:0]         fin;
        logic [IDX_W-1:0]         peak;
        logic signed [REF_W-1:0]  refi;
    } t_gap_offer;

    typedef struct packed {
        logic             valid;
        logic [IDX_W-1:0] beg;
        logic [LEN_W-1:0] fin;
        logic [IDX_W-1:0] peak;
    } t_gap_sel;

endpackage

// ===== rtl/sgfs_if.sv =====
// ----------------------------------------------------------------------------
// sgfs_if
// Valid/ready channels for range samples and selected gaps.
// ----------------------------------------------------------------------------
interface sgfs_req_if;
    logic                               valid;
    logic                               ready;
    logic [sgfs_pkg::RANGE_W-1:0]       range_mm;
    logic signed [sgfs_pkg::REF_W-1:0]  ref_index;

    modport source (output valid, output range_mm, output ref_index, input ready);
    modport sink   (input valid, input range_mm, input ref_index, output ready);
endinterface

interface sgfs_res_if;
    logic                          valid;
    logic                          ready;
    logic [sgfs_pkg::START_W-1:0]  gap_start;
    logic [sgfs_pkg::END_W-1:0]    gap_end;
    logic [sgfs_pkg::PEAK_W-1:0]   gap_peak;
    logic                          used_fallback;

    modport source (output valid, output gap_start, output gap_end, output gap_peak,
                    output used_fallback, input ready);
    modport sink   (input valid, input gap_start, input gap_end, input gap_peak,
                    input used_fallback, output ready);
endinterface

// ===== rtl/sgfs_cfg.sv =====
// ----------------------------------------------------------------------------
// sgfs_cfg
// Configuration registers and the scan bounds derived from them.
// ----------------------------------------------------------------------------
module sgfs_cfg (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [sgfs_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [sgfs_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    output sgfs_pkg::t_scan_cfg                o_cfg
);

    localparam int IDX_W = sgfs_pkg::IDX_W;
    localparam int LEN_W = sgfs_pkg::LEN_W;

    logic [sgfs_pkg::RANGE_W-1:0]   r_thr;
    logic [sgfs_pkg::MINGAP_W-1:0]  r_min_gap;
    logic [sgfs_pkg::SCANLEN_W-1:0] r_scan_len;
    logic [sgfs_pkg::FHW_W-1:0]     r_fhw;

    logic [LEN_W-1:0]       w_len;
    logic [IDX_W-1:0]       w_mid;
    logic [LEN_W-1:0]       w_fhw;
    logic [IDX_W-1:0]       w_ws;
    logic [LEN_W:0]         w_we_sum;
    logic [LEN_W-1:0]       w_we;
    sgfs_pkg::t_scan_cfg    n_cfg;
    sgfs_pkg::t_scan_cfg    r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr      <= sgfs_pkg::RST_THRESHOLD;
            r_min_gap  <= sgfs_pkg::RST_MIN_GAP;
            r_scan_len <= sgfs_pkg::RST_SCAN_LEN;
            r_fhw      <= sgfs_pkg::RST_FWD_HALF;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                sgfs_pkg::CFG_THRESHOLD: begin
                    r_thr <= i_cfg_data[sgfs_pkg::RANGE_W-1:0];
                end
                sgfs_pkg::CFG_MIN_GAP: begin
                    r_min_gap <= i_cfg_data[sgfs_pkg::MINGAP_W-1:0];
                end
                sgfs_pkg::CFG_SCAN_LEN: begin
                    r_scan_len <= i_cfg_data[sgfs_pkg::SCANLEN_W-1:0];
                end
                sgfs_pkg::CFG_FWD_HALF: begin
                    r_fhw <= i_cfg_data[sgfs_pkg::FHW_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // clamp length to [1, MAX_SAMPLES]
    always_comb begin
        if (r_scan_len == '0) begin
            w_len = LEN_W'(1);
        end else if (32'(r_scan_len) > sgfs_pkg::MAX_SAMPLES) begin
            w_len = LEN_W'(sgfs_pkg::MAX_SAMPLES);
        end else begin
            w_len = LEN_W'(r_scan_len);
        end
        w_mid    = IDX_W'(w_len >> 1);
        w_fhw    = LEN_W'(r_fhw);
        w_ws     = (LEN_W'(w_mid) > w_fhw) ? IDX_W'(LEN_W'(w_mid) - w_fhw) : '0;
        w_we_sum = (LEN_W+1)'(w_mid) + (LEN_W+1)'(w_fhw);
        w_we     = (w_we_sum > (LEN_W+1)'(w_len)) ? w_len : LEN_W'(w_we_sum);

        n_cfg.threshold = r_thr;
        n_cfg.min_gap   = r_min_gap;
        n_cfg.len       = w_len;
        n_cfg.last_idx  = IDX_W'(w_len - LEN_W'(1));
        n_cfg.ws        = w_ws;
        n_cfg.we        = w_we;
        n_cfg.start_lim = $signed((LEN_W+1)'(w_len)) - $signed((LEN_W+1)'(r_min_gap));
    end

    always_ff @(posedge i_clk) begin
        r_cfg <= n_cfg;
    end

    assign o_cfg = r_cfg;

endmodule

// ===== rtl/sgfs_gap_select.sv =====
// ----------------------------------------------------------------------------
// sgfs_gap_select
// Keeps the gap nearest the reference index as each gap closes.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sgfs_gap_select (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_step,
    input  logic                  i_clear,
    input  sgfs_pkg::t_gap_offer  i_offer,
    output sgfs_pkg::t_gap_sel    o_sel
);

    localparam int IDX_W  = sgfs_pkg::IDX_W;
    localparam int LEN_W  = sgfs_pkg::LEN_W;
    localparam int DIST_W = sgfs_pkg::DIST_W;
    localparam int SW     = sgfs_pkg::REF_W + 1;

    logic                r_valid;
    logic                r_contains;
    logic [IDX_W-1:0]    r_beg;
    logic [LEN_W-1:0]    r_fin;
    logic [IDX_W-1:0]    r_peak;
    logic [DIST_W-1:0]   r_dist;

    logic signed [SW-1:0] w_b;
    logic signed [SW-1:0] w_f;
    logic signed [SW-1:0] w_r;
    logic [DIST_W-1:0]    w_dist;
    logic                 w_inside;
    logic                 w_take;
    logic                 w_load;

    assign w_b = $signed(SW'(i_offer.beg));
    assign w_f = $signed(SW'(i_offer.fin));
    assign w_r = SW'(i_offer.refi);

    always_comb begin
        w_inside = 1'b0;
        w_dist   = '0;
        if (w_b > w_r) begin
            w_dist = DIST_W'(w_b - w_r);
        end else if (w_f < w_r) begin
            w_dist = DIST_W'(w_r - w_f);
        end else begin
            w_inside = 1'b1;
        end
    end

    // a containing gap is final; otherwise strictly nearer wins
    assign w_take = !r_valid || (!r_contains && (w_inside || (w_dist < r_dist)));
    assign w_load = i_offer.en && w_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= 1'b0;
            r_contains <= 1'b0;
        end else if (i_step) begin
            if (i_clear) begin
                r_valid    <= 1'b0;
                r_contains <= 1'b0;
            end else if (w_load) begin
                r_valid    <= 1'b1;
                r_contains <= w_inside;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step && w_load) begin
            r_beg  <= i_offer.beg;
            r_fin  <= i_offer.fin;
            r_peak <= i_offer.peak;
            r_dist <= w_dist;
        end
    end

    assign o_sel.valid = r_valid || w_load;
    assign o_sel.beg   = w_load ? i_offer.beg  : r_beg;
    assign o_sel.fin   = w_load ? i_offer.fin  : r_fin;
    assign o_sel.peak  = w_load ? i_offer.peak : r_peak;

    `SGFS_ASSERT_IMP(a_contains_valid, i_clk, i_rst_n, r_contains, r_valid)
    `SGFS_ASSERT_IMP(a_contains_zero, i_clk, i_rst_n, r_contains, r_dist == '0)
    `SGFS_ASSERT_NEXT(a_clear_empty, i_clk, i_rst_n, i_step && i_clear, !r_valid)

endmodule

// ===== rtl/scan_gap_finder_selector.sv =====
// ----------------------------------------------------------------------------
// scan_gap_finder_selector
// Streaming lidar gap search: picks the free gap nearest a reference index.
// ----------------------------------------------------------------------------
// Takes one range sample per clock, sustained, with samples of one scan
// following back to back and the next scan starting right after the last
// sample. Each sample passes an input register and then the state update
// (run tracking, window peak, gap selection); the scan result is written to
// an output register when its last sample leaves the input register and
// sits there while further samples keep flowing; only the last sample
// of the next scan waits for that register to drain. The update loop
// through the run and best-gap state sets this rate. Configuration writes
// take effect for samples accepted from the next cycle on.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module scan_gap_finder_selector (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    sgfs_req_if.sink                         i_req,
    sgfs_res_if.source                       o_res,
    input  logic                             i_cfg_we,
    input  logic [sgfs_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [sgfs_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    localparam int IDX_W    = sgfs_pkg::IDX_W;
    localparam int LEN_W    = sgfs_pkg::LEN_W;
    localparam int RANGE_W  = sgfs_pkg::RANGE_W;
    localparam int REF_W    = sgfs_pkg::REF_W;
    localparam int RUNLEN_W = sgfs_pkg::RUNLEN_W;

    sgfs_pkg::t_scan_cfg   w_cfg;
    sgfs_pkg::t_gap_offer  w_offer;
    sgfs_pkg::t_gap_sel    w_sel;

    logic                      r_in_valid;
    logic [RANGE_W-1:0]        r_in_range;
    logic signed [REF_W-1:0]   r_in_ref;

    logic [IDX_W-1:0]          r_cnt;
    logic [1:0]                r_phase;
    logic [IDX_W-1:0]          r_rbeg;
    logic [RUNLEN_W-1:0]       r_rlen;
    logic [RANGE_W-1:0]        r_rpv;
    logic [IDX_W-1:0]          r_rpi;
    logic signed [REF_W-1:0]   r_ref;
    logic [RANGE_W-1:0]        r_wpv;
    logic [IDX_W-1:0]          r_wpi;

    logic [1:0]                n_phase;
    logic [IDX_W-1:0]          n_rbeg;
    logic [RUNLEN_W-1:0]       n_rlen;
    logic [RANGE_W-1:0]        n_rpv;
    logic [IDX_W-1:0]          n_rpi;
    logic [RANGE_W-1:0]        n_wpv;
    logic [IDX_W-1:0]          n_wpi;

    logic                        r_out_valid;
    logic [sgfs_pkg::START_W-1:0] r_out_start;
    logic [sgfs_pkg::END_W-1:0]   r_out_end;
    logic [sgfs_pkg::PEAK_W-1:0]  r_out_peak;
    logic                        r_out_fb;

    logic                      w_adv;
    logic [RANGE_W-1:0]        w_range;
    logic [IDX_W-1:0]          w_idx;
    logic                      w_last;
    logic                      w_first;
    logic                      w_free;
    logic                      w_start_ok;
    logic [RUNLEN_W-1:0]       w_rlen_inc;
    logic                      w_close;

    sgfs_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (w_cfg)
    );

    // handshake; only the last sample of a scan needs the result register
    assign w_adv       = r_in_valid && (!w_last || !r_out_valid || o_res.ready);
    assign i_req.ready = !r_in_valid || w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_req.ready) begin
            r_in_valid <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_in_range <= i_req.range_mm;
            r_in_ref   <= i_req.ref_index;
        end
    end

    // per-sample decode
    assign w_range    = r_in_range & sgfs_pkg::RANGE_MASK;
    assign w_idx      = ({1'b0, r_cnt} >= w_cfg.len) ? w_cfg.last_idx : r_cnt;
    assign w_last     = (w_idx == w_cfg.last_idx);
    assign w_first    = (w_idx == '0);
    assign w_free     = (w_range > w_cfg.threshold);
    assign w_start_ok = ($signed({2'b00, w_idx}) < w_cfg.start_lim);
    assign w_rlen_inc = (r_rlen == '1) ? r_rlen : r_rlen + RUNLEN_W'(1);

    // forward window peak
    always_comb begin
        n_wpv = r_wpv;
        n_wpi = r_wpi;
        if (w_idx == w_cfg.ws) begin
            n_wpv = w_range;
            n_wpi = w_idx;
        end else if ((w_idx > w_cfg.ws) && ({1'b0, w_idx} < w_cfg.we)
                     && (w_range > r_wpv)) begin
            n_wpv = w_range;
            n_wpi = w_idx;
        end
    end

    // run tracking
    always_comb begin
        n_phase = r_phase;
        n_rbeg  = r_rbeg;
        n_rlen  = r_rlen;
        n_rpv   = r_rpv;
        n_rpi   = r_rpi;
        w_close = 1'b0;
        case (r_phase)
            sgfs_pkg::PH_IDLE: begin
                if (w_free && w_start_ok) begin
                    n_rbeg  = w_idx;
                    n_rlen  = RUNLEN_W'(1);
                    n_rpv   = w_range;
                    n_rpi   = w_idx;
                    n_phase = (RUNLEN_W'(1) >= w_cfg.min_gap) ? sgfs_pkg::PH_GAP
                                                               : sgfs_pkg::PH_CHECK;
                end
            end
            sgfs_pkg::PH_CHECK, sgfs_pkg::PH_GAP: begin
                if (w_free) begin
                    n_rlen = w_rlen_inc;
                    if (w_range > r_rpv) begin
                        n_rpv = w_range;
                        n_rpi = w_idx;
                    end
                    if ((r_phase == sgfs_pkg::PH_CHECK) && (w_rlen_inc >= w_cfg.min_gap)) begin
                        n_phase = sgfs_pkg::PH_GAP;
                    end
                end else begin
                    w_close = (r_phase == sgfs_pkg::PH_GAP);
                    n_phase = sgfs_pkg::PH_IDLE;
                end
            end
            default: begin
                n_phase = sgfs_pkg::PH_IDLE;
            end
        endcase
    end

    // a run closes on a blocked sample, or at scan end while still a gap
    assign w_offer.en   = w_close || (w_last && (n_phase == sgfs_pkg::PH_GAP));
    assign w_offer.beg  = n_rbeg;
    assign w_offer.fin  = w_close ? LEN_W'(w_idx) : w_cfg.len;
    assign w_offer.peak = n_rpi;
    assign w_offer.refi = w_first ? r_in_ref : r_ref;

    sgfs_gap_select u_sel (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (w_adv),
        .i_clear (w_last),
        .i_offer (w_offer),
        .o_sel   (w_sel)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt   <= '0;
            r_phase <= sgfs_pkg::PH_IDLE;
            r_wpv   <= '0;
            r_wpi   <= '0;
        end else if (w_adv) begin
            if (w_last) begin
                r_cnt   <= '0;
                r_phase <= sgfs_pkg::PH_IDLE;
                r_wpv   <= '0;
                r_wpi   <= '0;
            end else begin
                r_cnt   <= w_idx + IDX_W'(1);
                r_phase <= n_phase;
                r_wpv   <= n_wpv;
                r_wpi   <= n_wpi;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_rbeg <= n_rbeg;
            r_rlen <= n_rlen;
            r_rpv  <= n_rpv;
            r_rpi  <= n_rpi;
            if (w_first) begin
                r_ref <= r_in_ref;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv && w_last) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && w_last) begin
            if (w_sel.valid) begin
                r_out_start <= sgfs_pkg::START_W'(w_sel.beg);
                r_out_end   <= sgfs_pkg::END_W'(w_sel.fin);
                r_out_peak  <= sgfs_pkg::PEAK_W'(w_sel.peak);
                r_out_fb    <= 1'b0;
            end else begin
                r_out_start <= sgfs_pkg::START_W'(w_cfg.ws);
                r_out_end   <= sgfs_pkg::END_W'(w_cfg.we);
                r_out_peak  <= sgfs_pkg::PEAK_W'(n_wpi);
                r_out_fb    <= 1'b1;
            end
        end
    end

    assign o_res.valid         = r_out_valid;
    assign o_res.gap_start     = r_out_start;
    assign o_res.gap_end       = r_out_end;
    assign o_res.gap_peak      = r_out_peak;
    assign o_res.used_fallback = r_out_fb;

    `SGFS_ASSERT_NEXT(a_scan_restart, i_clk, i_rst_n, w_adv && w_last, r_cnt == '0)
    `SGFS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, r_out_valid && !o_res.ready, r_out_valid && $stable(r_out_start))
    `SGFS_ASSERT_IMP(a_ready_empty, i_clk, i_rst_n, !r_in_valid, i_req.ready)

endmodule

// ===== tb/gap_choice_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// gap_choice_checker
// Tracks each scan from the accepted range samples and the register writes.
// It predicts the gap, or the forward window, that closes every scan, and
// compares each returned result with the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module gap_choice_checker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    sgfs_req_if                              i_req,
    sgfs_res_if                              i_res,
    input  logic                             i_cfg_we,
    input  logic [sgfs_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [sgfs_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output int                               o_fail_count,
    output int                               o_pending
);

    localparam int RUN_LEN_MAX = (1 << sgfs_pkg::RUNLEN_W) - 1;

    typedef struct packed {
        logic [sgfs_pkg::START_W-1:0] gap_start;
        logic [sgfs_pkg::END_W-1:0]   gap_end;
        logic [sgfs_pkg::PEAK_W-1:0]  gap_peak;
        logic                         used_fallback;
    } t_gap_choice;

    int threshold, min_gap, scan_len, fwd_half;

    int         sample_count;
    logic [1:0] run_phase;
    int         run_begin, run_length, run_peak_value, run_peak_index;
    int         ref_latched;
    int         best_begin, best_finish, best_peak, best_distance;
    bit         best_valid, best_contains;
    int         window_peak_value, window_peak_index;

    int          fail_count;
    t_gap_choice expected_choices[$];

    function automatic void clear_scan();
        sample_count      = 0;
        run_phase         = sgfs_pkg::PH_IDLE;
        run_begin         = 0;
        run_length        = 0;
        run_peak_value    = 0;
        run_peak_index    = 0;
        ref_latched       = 0;
        best_begin        = 0;
        best_finish       = 0;
        best_peak         = 0;
        best_distance     = 0;
        best_valid        = 1'b0;
        best_contains     = 1'b0;
        window_peak_value = 0;
        window_peak_index = 0;
    endfunction

    // distance is zero when the reference lies in the gap; once such a gap is
    // kept it stays, otherwise only a strictly nearer gap replaces the kept one
    function automatic void weigh_gap(input int finish);
        int gap_dist;
        bit holds_ref;
        bit take;
        holds_ref = 1'b0;
        if (run_begin > ref_latched) begin
            gap_dist = run_begin - ref_latched;
        end else if (finish < ref_latched) begin
            gap_dist = ref_latched - finish;
        end else begin
            gap_dist  = 0;
            holds_ref = 1'b1;
        end
        if (!best_valid) take = 1'b1;
        else if (best_contains) take = 1'b0;
        else if (holds_ref) take = 1'b1;
        else take = (gap_dist < best_distance);
        if (take) begin
            best_begin    = run_begin;
            best_finish   = finish;
            best_peak     = run_peak_index;
            best_distance = gap_dist;
            best_valid    = 1'b1;
            best_contains = holds_ref;
        end
    endfunction

    function automatic void advance_scan(
        input logic [sgfs_pkg::RANGE_W-1:0]      range_mm,
        input logic signed [sgfs_pkg::REF_W-1:0] ref_index
    );
        int          len, idx, mid, win_start, win_end, range_val;
        bit          free_sample;
        t_gap_choice choice;
        range_val = range_mm & sgfs_pkg::RANGE_MASK;
        len = scan_len;
        if (len < 1) len = 1;
        if (len > sgfs_pkg::MAX_SAMPLES) len = sgfs_pkg::MAX_SAMPLES;
        idx = (sample_count >= len) ? len - 1 : sample_count;
        free_sample = range_val > threshold;
        if (idx == 0) ref_latched = ref_index;

        mid       = len / 2;
        win_start = (mid > fwd_half) ? mid - fwd_half : 0;
        win_end   = (mid + fwd_half > len) ? len : mid + fwd_half;
        if (idx == win_start) begin
            window_peak_value = range_val;
            window_peak_index = idx;
        end else if (idx > win_start && idx < win_end && range_val > window_peak_value) begin
            window_peak_value = range_val;
            window_peak_index = idx;
        end

        if (run_phase == sgfs_pkg::PH_IDLE) begin
            if (free_sample && idx < len - min_gap) begin
                run_begin      = idx;
                run_length     = 1;
                run_peak_value = range_val;
                run_peak_index = idx;
                run_phase      = (run_length >= min_gap) ? sgfs_pkg::PH_GAP
                                                         : sgfs_pkg::PH_CHECK;
            end
        end else if (free_sample) begin
            if (run_length < RUN_LEN_MAX) run_length++;
            if (range_val > run_peak_value) begin
                run_peak_value = range_val;
                run_peak_index = idx;
            end
            if (run_phase == sgfs_pkg::PH_CHECK && run_length >= min_gap) begin
                run_phase = sgfs_pkg::PH_GAP;
            end
        end else begin
            if (run_phase == sgfs_pkg::PH_GAP) weigh_gap(idx);
            run_phase = sgfs_pkg::PH_IDLE;
        end

        if (idx + 1 < len) begin
            sample_count = idx + 1;
            return;
        end

        // last sample: a confirmed run closes at the scan length
        if (run_phase == sgfs_pkg::PH_GAP) weigh_gap(len);
        if (best_valid) begin
            choice.gap_start     = sgfs_pkg::START_W'(best_begin);
            choice.gap_end       = sgfs_pkg::END_W'(best_finish);
            choice.gap_peak      = sgfs_pkg::PEAK_W'(best_peak);
            choice.used_fallback = 1'b0;
        end else begin
            choice.gap_start     = sgfs_pkg::START_W'(win_start);
            choice.gap_end       = sgfs_pkg::END_W'(win_end);
            choice.gap_peak      = sgfs_pkg::PEAK_W'(window_peak_index);
            choice.used_fallback = 1'b1;
        end
        expected_choices = {expected_choices, choice};
        clear_scan();
    endfunction

    function automatic void check_field(input string name, input logic [15:0] want,
                                        input logic [15:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            fail_count++;
        end
    endfunction

    function automatic void check_choice();
        t_gap_choice want;
        if (expected_choices.size() == 0) begin
            $error("result with none expected: start %0d end %0d peak %0d fallback %0d",
                   i_res.gap_start, i_res.gap_end, i_res.gap_peak, i_res.used_fallback);
            fail_count++;
            return;
        end
        want = expected_choices.pop_front();
        check_field("gap_start", want.gap_start, i_res.gap_start);
        check_field("gap_end", want.gap_end, i_res.gap_end);
        check_field("gap_peak", want.gap_peak, i_res.gap_peak);
        check_field("used_fallback", want.used_fallback, i_res.used_fallback);
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            threshold  = sgfs_pkg::RST_THRESHOLD;
            min_gap    = sgfs_pkg::RST_MIN_GAP;
            scan_len   = sgfs_pkg::RST_SCAN_LEN;
            fwd_half   = sgfs_pkg::RST_FWD_HALF;
            fail_count = 0;
            expected_choices.delete();
            clear_scan();
        end else begin
            if (i_res.valid && i_res.ready) check_choice();
            if (i_req.valid && i_req.ready) advance_scan(i_req.range_mm, i_req.ref_index);
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    sgfs_pkg::CFG_THRESHOLD: threshold = i_cfg_data[sgfs_pkg::RANGE_W-1:0];
                    sgfs_pkg::CFG_MIN_GAP:   min_gap   = i_cfg_data[sgfs_pkg::MINGAP_W-1:0];
                    sgfs_pkg::CFG_SCAN_LEN:  scan_len  = i_cfg_data[sgfs_pkg::SCANLEN_W-1:0];
                    sgfs_pkg::CFG_FWD_HALF:  fwd_half  = i_cfg_data[sgfs_pkg::FHW_W-1:0];
                    default: ;
                endcase
            end
        end
        o_pending    <= expected_choices.size();
        o_fail_count <= fail_count;
    end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Streams lidar scans into the gap finder under a series of register
// settings: a short hand-made set of scans, fixed settings at the register
// extremes, a receiver hold-off that backs up the block, then random scans.
// Random idles on both channels; the checker beside the block judges results.
// ----------------------------------------------------------------------------
module testbench;

    localparam int HOLD_OFF_CYCLES = 300;
    localparam int SETTLE_CYCLES   = 6;
    localparam int STALL_LIMIT     = 2000;
    localparam int RANDOM_ITEMS    = 180;
    localparam int RANGE_W         = sgfs_pkg::RANGE_W;
    localparam int REF_W           = sgfs_pkg::REF_W;
    localparam int CFG_DATA_W      = sgfs_pkg::CFG_DATA_W;

    logic                            i_clk    = 1'b0;
    logic                            i_rst_n  = 1'b0;
    logic                            cfg_we   = 1'b0;
    logic [sgfs_pkg::CFG_IDX_W-1:0]  cfg_idx  = sgfs_pkg::CFG_THRESHOLD;
    logic [CFG_DATA_W-1:0]           cfg_data = '0;

    int fail_count;
    int pending;
    int quiet_cycles = 0;
    int items_sent   = 0;
    bit idle_on          = 1'b1;
    bit stall_on         = 1'b1;
    bit hold_off_pending = 1'b0;

    int cur_thr = sgfs_pkg::RST_THRESHOLD;
    int cur_mg  = sgfs_pkg::RST_MIN_GAP;
    int cur_len = sgfs_pkg::RST_SCAN_LEN;
    bit run_free = 1'b0;
    int run_left = 0;

    logic [RANGE_W-1:0] listed_ranges[$];

    sgfs_req_if req_ch();
    sgfs_res_if res_ch();

    scan_gap_finder_selector u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (req_ch.sink),
        .o_res      (res_ch.source),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    gap_choice_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (req_ch),
        .i_res        (res_ch),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always #2 i_clk = ~i_clk;

    // free and blocked stretches alternate, lengths around the minimum gap
    function automatic logic [RANGE_W-1:0] pick_range();
        int span;
        if (run_left == 0) begin
            run_free = ~run_free;
            span = 2 * cur_mg + 3;
            if (span > 300) span = 300;
            run_left = $urandom_range(1, span);
        end
        run_left--;
        if ($urandom_range(0, 19) == 0) return RANGE_W'($urandom);
        if (run_free && cur_thr < 65535) return RANGE_W'($urandom_range(cur_thr + 1, 65535));
        return RANGE_W'($urandom_range(0, cur_thr));
    endfunction

    function automatic logic signed [REF_W-1:0] pick_reference();
        if ($urandom_range(0, 7) == 0) return REF_W'($urandom);
        return REF_W'(int'($urandom_range(0, cur_len + 3)) - 2);
    endfunction

    task automatic send_sample(input logic [RANGE_W-1:0] range_mm,
                               input logic signed [REF_W-1:0] ref_index);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
        end
        req_ch.valid     <= 1'b1;
        req_ch.range_mm  <= range_mm;
        req_ch.ref_index <= ref_index;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_random(input int count);
        repeat (count) send_sample(pick_range(), pick_reference());
        req_ch.valid <= 1'b0;
    endtask

    task automatic send_listed(input logic signed [REF_W-1:0] first_ref);
        foreach (listed_ranges[k])
            send_sample(listed_ranges[k], (k == 0) ? first_ref : pick_reference());
        req_ch.valid <= 1'b0;
    endtask

    // only with no scan result outstanding; unused upper data bits are junk
    task automatic configure(input int thr, input int mg, input int len, input int fhw);
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= sgfs_pkg::CFG_THRESHOLD;
        cfg_data <= CFG_DATA_W'(thr);
        @(negedge i_clk);
        cfg_idx  <= sgfs_pkg::CFG_MIN_GAP;
        cfg_data <= {4'($urandom), 12'(mg)};
        @(negedge i_clk);
        cfg_idx  <= sgfs_pkg::CFG_SCAN_LEN;
        cfg_data <= {4'($urandom), 12'(len)};
        @(negedge i_clk);
        cfg_idx  <= sgfs_pkg::CFG_FWD_HALF;
        cfg_data <= {5'($urandom), 11'(fhw)};
        @(negedge i_clk);
        cfg_we <= 1'b0;
        cur_thr = thr;
        cur_mg  = mg;
        cur_len = (len < 1) ? 1 : (len > sgfs_pkg::MAX_SAMPLES) ? sgfs_pkg::MAX_SAMPLES : len;
    endtask

    task automatic run_setting(input int thr, input int mg, input int len, input int fhw,
                               input int scans, input int extra);
        configure(thr, mg, len, fhw);
        send_random(scans * cur_len + extra);
    endtask

    initial begin
        res_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_off_pending) begin
                hold_off_pending = 1'b0;
                res_ch.ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES - 1) @(negedge i_clk);
            end else if (stall_on && $urandom_range(0, 4) == 0) begin
                res_ch.ready <= 1'b0;
                repeat ($urandom_range(0, 5)) @(negedge i_clk);
            end else begin
                res_ch.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        int target;
        int len;
        int thr;
        req_ch.valid     = 1'b0;
        req_ch.range_mm  = '0;
        req_ch.ref_index = '0;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // short run dropped, gap holding the reference, late run too close to the end
        configure(1000, 3, 12, 2);
        listed_ranges = '{16'd65535, 16'd65535, 16'd0, 16'd2000, 16'd3000, 16'd2500,
                          16'd0, 16'd1001, 16'd1001, 16'd1001, 16'd1001, 16'd1000};
        send_listed(REF_W'(5));
        listed_ranges = '{16'd0, 16'd1500, 16'd1500, 16'd1500, 16'd0, 16'd0,
                          16'd0, 16'd0, 16'd0, 16'd65535, 16'd65535, 16'd65535};
        send_listed(REF_W'(4095));
        configure(65535, 1, 2, 0);
        listed_ranges = '{16'd65535, 16'd0};
        send_listed(REF_W'(-4096));

        run_setting(1500, 4, 40, 5, 2, 0);
        run_setting(0, 0, 20, 0, 4, 0);
        run_setting(65535, 1, 16, 2047, 3, 0);
        run_setting(30000, 2048, 24, 3, 3, 0);
        run_setting(20000, 4095, 0, 9, 6, 0);

        // results back up while the receiver holds off
        configure(20000, 3, 2, 1);
        hold_off_pending = 1'b1;
        send_random(60);

        // oversized scan length, left unfinished and then cut short
        run_setting(10000, 40, 4095, 1024, 0, 100);

        // scan length cut below the current sample position
        run_setting(8000, 3, 30, 4, 2, 20);
        run_setting(8000, 3, 10, 4, 3, 0);

        target = items_sent + RANDOM_ITEMS;
        while (items_sent < target) begin
            idle_on  = ($urandom_range(0, 3) != 0);
            stall_on = ($urandom_range(0, 3) != 0);
            len = $urandom_range(2, 48);
            thr = ($urandom_range(0, 7) == 0) ? 0 :
                  ($urandom_range(0, 7) == 0) ? 65535 : $urandom_range(200, 60000);
            run_setting(thr, $urandom_range(0, 8), len,
                        ($urandom_range(0, 7) == 0) ? 2047 : $urandom_range(0, 30),
                        $urandom_range(1, 4),
                        ($urandom_range(0, 3) == 0) ? $urandom_range(1, len - 1) : 0);
        end

        idle_on  = 1'b0;
        stall_on = 1'b0;
        run_setting(5000, 3, 20, 4, 3, 0);

        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
